FILE: hdl/cubic_bezier_flattener_macros.svh
// Assertion helpers shared by the flattener RTL.
`ifndef CUBIC_BEZIER_FLATTENER_MACROS_SVH
`define CUBIC_BEZIER_FLATTENER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define CBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cbf_pkg.sv
package cbf_pkg;

  // Segment count per curve, clamped to the supported range.
  localparam int SEGMENTS = 64;
  localparam int SEG_N    = (SEGMENTS < 1) ? 1 : ((SEGMENTS > 64) ? 64 : SEGMENTS);

  // The Bernstein weights of one step sum to SEG_N cubed.
  localparam int DIV  = SEG_N * SEG_N * SEG_N;
  localparam int HALF = DIV / 2;

  // Widths: weight, weighted sum, step counter, quotient.
  localparam int CW     = $clog2(DIV + 1);
  localparam int NW     = CW + 32;
  localparam int CNTW   = $clog2(SEG_N + 1);
  localparam int QW     = 32;
  localparam int DSTEPS = QW / 2;

  // Pipeline: issue, multiply, two adds, rounding offset, then the divider steps.
  localparam int NST   = DSTEPS + 5;
  localparam int NTERM = 4;
  localparam int NLANE = 2;

  typedef logic [SEG_N:0][NTERM-1:0][CW-1:0] coef_tab_t;

  // Flags and start point that travel with each point down the pipeline.
  typedef struct packed {
    logic        first;
    logic        last;
    logic [31:0] sx;
    logic [31:0] sy;
  } seg_meta_t;

  // Integer Bernstein weights u^3, 3u^2 i, 3u i^2, i^3 with u = SEG_N - i.
  function automatic coef_tab_t build_coef_tab();
    coef_tab_t tab;
    int        u;
    tab = '0;
    for (int i = 0; i <= SEG_N; i++) begin
      u         = SEG_N - i;
      tab[i][0] = CW'(u * u * u);
      tab[i][1] = CW'(3 * u * u * i);
      tab[i][2] = CW'(3 * u * i * i);
      tab[i][3] = CW'(i * i * i);
    end
    return tab;
  endfunction

  localparam coef_tab_t COEF_TAB = build_coef_tab();

endpackage

FILE: hdl/cubic_bezier_flattener.sv
// Cubic Bezier flattener.
// Input channel (in_valid/in_ready): one curve per item, start and end anchors
// and two control points, all signed Q16.16.
// Output channel (out_valid/out_ready): SEGMENTS line segments per curve, in
// order of rising t, each carrying both end points; out_last_segment marks the
// final one. Points are rounded to nearest, ties away from zero.
// A curve lands in a one-entry input buffer, so in_ready only drops while that
// buffer is full. The sequencer issues one point per cycle while the output
// is not stalled, and a new curve follows straight on; sustained output is one
// segment per cycle while the receiver stays ready. The first segment of a
// curve taken into an empty block passes the buffer, sequencer, multiply, two
// adds, rounding, sixteen two-bit divider steps and the output register.
// When the receiver stalls, the whole point pipeline holds in place and the
// input buffer can still take one curve. Synchronous reset empties the buffer,
// the sequencer and every pipeline valid bit; no partial curve survives it.
`include "cubic_bezier_flattener_macros.svh"

module cubic_bezier_flattener (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_ctrl_a_x,
  input  logic signed [31:0] in_ctrl_a_y,
  input  logic signed [31:0] in_ctrl_b_x,
  input  logic signed [31:0] in_ctrl_b_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_seg_x0,
  output logic signed [31:0] out_seg_y0,
  output logic signed [31:0] out_seg_x1,
  output logic signed [31:0] out_seg_y1,
  output logic               out_last_segment
);

  localparam int CW     = cbf_pkg::CW;
  localparam int NW     = cbf_pkg::NW;
  localparam int RW     = cbf_pkg::CW;
  localparam int CNTW   = cbf_pkg::CNTW;
  localparam int QW     = cbf_pkg::QW;
  localparam int DSTEPS = cbf_pkg::DSTEPS;
  localparam int NST    = cbf_pkg::NST;
  localparam int NTERM  = cbf_pkg::NTERM;
  localparam int NLANE  = cbf_pkg::NLANE;

  localparam logic [RW+1:0] DIV_1 = (RW + 2)'(cbf_pkg::DIV);
  localparam logic [RW+1:0] DIV_2 = (RW + 2)'(2 * cbf_pkg::DIV);
  localparam logic [RW+1:0] DIV_3 = (RW + 2)'(3 * cbf_pkg::DIV);
  localparam logic [31:0]   POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]   NEG_MAX = 32'h8000_0000;

  // Input buffer and sequencer.
  logic                buf_valid_r, buf_valid_nxt;
  logic signed [31:0]  buf_pt_r [NLANE][NTERM];
  logic                busy_r, busy_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic signed [31:0]  cur_pt_r [NLANE][NTERM];
  logic                advance, issue, issue_last, buf_take;

  // Pipeline valid bits and side data.
  logic                vld_r  [NST];
  cbf_pkg::seg_meta_t  meta_r [NST];

  // Arithmetic stages.
  logic [CW-1:0]       coef_r [NTERM];
  logic signed [31:0]  pt_r [NLANE][NTERM];
  logic signed [NW:0]  prod_full [NLANE][NTERM];
  logic signed [NW-1:0] prod_r [NLANE][NTERM];
  logic signed [NW-1:0] sa_r [NLANE][2];
  logic signed [NW-1:0] num_r [NLANE];
  logic [NW-1:0]       m2 [NLANE];

  // Divider steps: remainder, dividend bits shifting out and quotient bits in.
  logic [RW-1:0]       rem_r [DSTEPS+1][NLANE];
  logic [QW-1:0]       lo_r  [DSTEPS+1][NLANE];
  logic                neg_r [DSTEPS+1][NLANE];
  logic [RW-1:0]       rem_nxt [DSTEPS][NLANE];
  logic [QW-1:0]       lo_nxt  [DSTEPS][NLANE];

  // Output side.
  logic signed [31:0]  fin [NLANE];
  logic signed [31:0]  prev_r [NLANE];
  logic                out_valid_r;
  logic signed [31:0]  seg_x0_r, seg_y0_r, seg_x1_r, seg_y1_r;
  logic                last_r;

  // The whole point pipeline moves whenever the output register can take a value.
  assign advance    = !out_valid_r || out_ready;
  assign in_ready   = !buf_valid_r;
  assign issue      = busy_r && advance;
  assign issue_last = issue && (cnt_r == CNTW'(cbf_pkg::SEG_N));
  assign buf_take   = buf_valid_r && (!busy_r || issue_last);

  // Sequencer next state: load a buffered curve, step through the points.
  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    buf_valid_nxt = buf_valid_r;
    priority if (buf_take) begin
      busy_nxt      = 1'b1;
      cnt_nxt       = CNTW'(1);
      buf_valid_nxt = 1'b0;
    end else if (issue_last) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (in_valid && in_ready) begin
      buf_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      buf_valid_r <= buf_valid_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      if (advance) begin
        vld_r[0] <= issue;
        for (int s = 1; s < NST; s++) begin
          vld_r[s] <= vld_r[s-1];
        end
        out_valid_r <= vld_r[NST-1];
      end
    end
  end

  // Curve capture: lane 0 is x, lane 1 is y; terms in Bernstein order.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_pt_r[0][0] <= in_start_x;
      buf_pt_r[0][1] <= in_ctrl_a_x;
      buf_pt_r[0][2] <= in_ctrl_b_x;
      buf_pt_r[0][3] <= in_end_x;
      buf_pt_r[1][0] <= in_start_y;
      buf_pt_r[1][1] <= in_ctrl_a_y;
      buf_pt_r[1][2] <= in_ctrl_b_y;
      buf_pt_r[1][3] <= in_end_y;
    end
    if (buf_take) begin
      cur_pt_r <= buf_pt_r;
    end
  end

  // Weighted terms, the rounding offset and one divider step per stage.
  always_comb begin
    logic [RW+1:0] t;
    logic [RW+1:0] r;
    logic [1:0]    q2;
    t  = '0;
    r  = '0;
    q2 = '0;
    for (int l = 0; l < NLANE; l++) begin
      for (int j = 0; j < NTERM; j++) begin
        prod_full[l][j] = $signed({1'b0, coef_r[j]}) * pt_r[l][j];
      end
      // Magnitude plus half the divisor; negation folded into the same add.
      if (num_r[l][NW-1]) begin
        m2[l] = (~num_r[l]) + NW'(cbf_pkg::HALF + 1);
      end else begin
        m2[l] = num_r[l] + NW'(cbf_pkg::HALF);
      end
    end
    for (int k = 0; k < DSTEPS; k++) begin
      for (int l = 0; l < NLANE; l++) begin
        t = {rem_r[k][l], lo_r[k][l][QW-1 -: 2]};
        priority if (t >= DIV_3) begin
          q2 = 2'd3;
          r  = t - DIV_3;
        end else if (t >= DIV_2) begin
          q2 = 2'd2;
          r  = t - DIV_2;
        end else if (t >= DIV_1) begin
          q2 = 2'd1;
          r  = t - DIV_1;
        end else begin
          q2 = 2'd0;
          r  = t;
        end
        rem_nxt[k][l] = r[RW-1:0];
        lo_nxt[k][l]  = {lo_r[k][l][QW-3:0], q2};
      end
    end
  end

  // Apply the sign and clamp to the 32-bit range.
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (neg_r[DSTEPS][l]) begin
        fin[l] = (lo_r[DSTEPS][l] > NEG_MAX) ? NEG_MAX : -lo_r[DSTEPS][l];
      end else begin
        fin[l] = lo_r[DSTEPS][l][QW-1] ? POS_MAX : lo_r[DSTEPS][l];
      end
    end
  end

  // Datapath registers, all held while the output is stalled.
  always_ff @(posedge clk) begin
    if (advance) begin
      // Issue stage.
      for (int j = 0; j < NTERM; j++) begin
        coef_r[j] <= cbf_pkg::COEF_TAB[cnt_r][j];
      end
      pt_r            <= cur_pt_r;
      meta_r[0].first <= (cnt_r == CNTW'(1));
      meta_r[0].last  <= (cnt_r == CNTW'(cbf_pkg::SEG_N));
      meta_r[0].sx    <= cur_pt_r[0][0];
      meta_r[0].sy    <= cur_pt_r[1][0];
      for (int s = 1; s < NST; s++) begin
        meta_r[s] <= meta_r[s-1];
      end
      for (int l = 0; l < NLANE; l++) begin
        // Multiply, then the two-level sum.
        for (int j = 0; j < NTERM; j++) begin
          prod_r[l][j] <= prod_full[l][j][NW-1:0];
        end
        sa_r[l][0] <= prod_r[l][0] + prod_r[l][1];
        sa_r[l][1] <= prod_r[l][2] + prod_r[l][3];
        num_r[l]   <= sa_r[l][0] + sa_r[l][1];
        // Divider entry: top bits form the first remainder.
        rem_r[0][l] <= m2[l][NW-1:QW];
        lo_r[0][l]  <= m2[l][QW-1:0];
        neg_r[0][l] <= num_r[l][NW-1];
        for (int k = 0; k < DSTEPS; k++) begin
          rem_r[k+1][l] <= rem_nxt[k][l];
          lo_r[k+1][l]  <= lo_nxt[k][l];
          neg_r[k+1][l] <= neg_r[k][l];
        end
      end
    end
  end

  // Output register: pair each point with the one before it in the curve.
  always_ff @(posedge clk) begin
    if (advance && vld_r[NST-1]) begin
      seg_x0_r  <= meta_r[NST-1].first ? meta_r[NST-1].sx : prev_r[0];
      seg_y0_r  <= meta_r[NST-1].first ? meta_r[NST-1].sy : prev_r[1];
      seg_x1_r  <= fin[0];
      seg_y1_r  <= fin[1];
      last_r    <= meta_r[NST-1].last;
      prev_r[0] <= fin[0];
      prev_r[1] <= fin[1];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_seg_x0       = seg_x0_r;
  assign out_seg_y0       = seg_y0_r;
  assign out_seg_x1       = seg_x1_r;
  assign out_seg_y1       = seg_y1_r;
  assign out_last_segment = last_r;

  // The step counter stays within one curve's points while busy.
  `CBF_ASSERT_NOW(a_cnt_range, busy_r, (cnt_r != '0) && (cnt_r <= CNTW'(cbf_pkg::SEG_N)), "step counter out of range")
  // The final divider remainder stays below the divisor.
  `CBF_ASSERT_NOW(a_rem_x, vld_r[NST-1], rem_r[DSTEPS][0] < RW'(cbf_pkg::DIV), "x remainder not reduced")
  `CBF_ASSERT_NOW(a_rem_y, vld_r[NST-1], rem_r[DSTEPS][1] < RW'(cbf_pkg::DIV), "y remainder not reduced")
  // A convex combination never needs more than 2^31 in magnitude.
  `CBF_ASSERT_NOW(a_quot_x, vld_r[NST-1], lo_r[DSTEPS][0] <= NEG_MAX, "x quotient beyond range")
  // A point waiting at the pipeline end is not lost while the output stalls.
  `CBF_ASSERT_NEXT(a_hold_tail, vld_r[NST-1] && !advance, vld_r[NST-1], "point dropped during stall")

endmodule

FILE: sim/cubic_bezier_flattener_test.sv
module cubic_bezier_flattener_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SEG        = cbf_pkg::SEG_N;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 5000;
  localparam int REPORT_LIMIT = 60;
  localparam int RANDOM_ITEMS = 170;

  // One curve as offered on the input channel.
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] ctrl_a_x;
    logic signed [31:0] ctrl_a_y;
    logic signed [31:0] ctrl_b_x;
    logic signed [31:0] ctrl_b_y;
  } curve_t;

  // One line segment as produced on the output channel.
  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic               last;
  } segment_t;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_start_x       = '0;
  logic signed [31:0] in_start_y       = '0;
  logic signed [31:0] in_end_x         = '0;
  logic signed [31:0] in_end_y         = '0;
  logic signed [31:0] in_ctrl_a_x      = '0;
  logic signed [31:0] in_ctrl_a_y      = '0;
  logic signed [31:0] in_ctrl_b_x      = '0;
  logic signed [31:0] in_ctrl_b_y      = '0;
  logic               out_valid;
  logic               out_ready        = 1'b0;
  logic signed [31:0] out_seg_x0;
  logic signed [31:0] out_seg_y0;
  logic signed [31:0] out_seg_x1;
  logic signed [31:0] out_seg_y1;
  logic               out_last_segment;

  // Segments predicted for accepted curves, oldest first.
  segment_t expected_segments[$];
  int       fail_count   = 0;
  int       quiet_cycles = 0;

  // Knobs shared between the stimulus, the sender and the receiver.
  bit send_gaps_on = 1'b0;
  bit sink_idle_on = 1'b0;
  bit hold_request = 1'b0;

  cubic_bezier_flattener u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_ctrl_a_x      (in_ctrl_a_x),
    .in_ctrl_a_y      (in_ctrl_a_y),
    .in_ctrl_b_x      (in_ctrl_b_x),
    .in_ctrl_b_y      (in_ctrl_b_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_seg_x0       (out_seg_x0),
    .out_seg_y0       (out_seg_y0),
    .out_seg_x1       (out_seg_x1),
    .out_seg_y1       (out_seg_y1),
    .out_last_segment (out_last_segment)
  );

  always #10 clk = ~clk;

  // One coordinate of the Bernstein point at a step, as the exact weighted sum
  // divided by the cube of the segment count, rounded half away from zero.
  function automatic logic signed [31:0] bezier_coord(
      input logic signed [31:0] p0, p1, p2, p3, input int step);
    longint n, u, i, d, num, mag, q;
    n   = N_SEG;
    i   = step;
    u   = n - i;
    d   = n * n * n;
    num = u * u * u * longint'(p0) + 3 * u * u * i * longint'(p1)
        + 3 * u * i * i * longint'(p2) + i * i * i * longint'(p3);
    mag = (num < 0) ? -num : num;
    q   = (mag + d / 2) / d;
    if (num < 0) begin
      q = -q;
    end
    // Guard clamp; a convex combination stays inside the range anyway.
    if (q > longint'(32'sh7fff_ffff)) begin
      q = longint'(32'sh7fff_ffff);
    end
    if (q < longint'(32'sh8000_0000)) begin
      q = longint'(32'sh8000_0000);
    end
    return q[31:0];
  endfunction

  // Works out every segment of an accepted curve and queues them in order.
  task automatic flatten_curve(input curve_t c);
    segment_t           seg;
    logic signed [31:0] px, py, x, y;
    px = bezier_coord(c.start_x, c.ctrl_a_x, c.ctrl_b_x, c.end_x, 0);
    py = bezier_coord(c.start_y, c.ctrl_a_y, c.ctrl_b_y, c.end_y, 0);
    for (int k = 1; k <= N_SEG; k++) begin
      x        = bezier_coord(c.start_x, c.ctrl_a_x, c.ctrl_b_x, c.end_x, k);
      y        = bezier_coord(c.start_y, c.ctrl_a_y, c.ctrl_b_y, c.end_y, k);
      seg.x0   = px;
      seg.y0   = py;
      seg.x1   = x;
      seg.y1   = y;
      seg.last = (k == N_SEG);
      expected_segments.push_back(seg);
      px = x;
      py = y;
    end
  endtask

  // Random idle length for the sender and receiver; now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end
    if (r < 92) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Coordinate drawn from one of several regions of the Q16.16 range.
  function automatic logic signed [31:0] rand_coord(input int style);
    case (style)
      0: begin
        return $urandom_range(0, 8191) - 4096;
      end
      1: begin
        return 32'sh7fff_ffff - $urandom_range(0, 65535);
      end
      2: begin
        return 32'sh8000_0000 + $urandom_range(0, 65535);
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic curve_t rand_curve();
    curve_t c;
    int     style;
    style      = $urandom_range(0, 9);
    // Most curves use the full range; some stay small or hug one extreme.
    style      = (style < 6) ? 3 : ((style < 8) ? 0 : style - 7);
    c.start_x  = rand_coord(style);
    c.start_y  = rand_coord(style);
    c.end_x    = rand_coord(style);
    c.end_y    = rand_coord(style);
    c.ctrl_a_x = rand_coord(style);
    c.ctrl_a_y = rand_coord(style);
    c.ctrl_b_x = rand_coord(style);
    c.ctrl_b_y = rand_coord(style);
    // Now and then mix regions point by point.
    if ($urandom_range(0, 4) == 0) begin
      c.ctrl_a_x = rand_coord($urandom_range(0, 3));
      c.ctrl_b_y = rand_coord($urandom_range(0, 3));
      c.end_x    = rand_coord($urandom_range(0, 3));
    end
    return c;
  endfunction

  // Offers one curve, waits for its acceptance and queues its segments.
  task automatic send_curve(input curve_t c);
    int gap;
    gap = (send_gaps_on && $urandom_range(0, 1) == 1) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_start_x  <= c.start_x;
    in_start_y  <= c.start_y;
    in_end_x    <= c.end_x;
    in_end_y    <= c.end_y;
    in_ctrl_a_x <= c.ctrl_a_x;
    in_ctrl_a_y <= c.ctrl_a_y;
    in_ctrl_b_x <= c.ctrl_b_x;
    in_ctrl_b_y <= c.ctrl_b_y;
    do begin
      @(posedge clk);
    end while (!in_ready);
    flatten_curve(c);
  endtask

  function automatic curve_t same_point_curve(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    curve_t c;
    c.start_x  = x;
    c.start_y  = y;
    c.end_x    = x;
    c.end_y    = y;
    c.ctrl_a_x = x;
    c.ctrl_a_y = y;
    c.ctrl_b_x = x;
    c.ctrl_b_y = y;
    return c;
  endfunction

  // Corners of the coordinate range, alone and against each other.
  task automatic test_range_extremes();
    curve_t c;
    send_curve(same_point_curve(32'sh7fff_ffff, 32'sh7fff_ffff));
    send_curve(same_point_curve(32'sh8000_0000, 32'sh8000_0000));
    send_curve(same_point_curve('0, '0));
    c.start_x  = 32'sh8000_0000;
    c.start_y  = 32'sh7fff_ffff;
    c.end_x    = 32'sh7fff_ffff;
    c.end_y    = 32'sh8000_0000;
    c.ctrl_a_x = 32'sh7fff_ffff;
    c.ctrl_a_y = 32'sh8000_0000;
    c.ctrl_b_x = 32'sh8000_0000;
    c.ctrl_b_y = 32'sh7fff_ffff;
    send_curve(c);
    send_curve(~c);
    c.start_x  = 32'sh7fff_ffff;
    c.start_y  = 32'sh7fff_ffff;
    c.end_x    = 32'sh8000_0000;
    c.end_y    = 32'sh8000_0000;
    c.ctrl_a_x = 32'sh8000_0000;
    c.ctrl_a_y = 32'sh7fff_ffff;
    c.ctrl_b_x = 32'sh7fff_ffff;
    c.ctrl_b_y = 32'sh8000_0000;
    send_curve(c);
  endtask

  // All four points equal gives segments of zero length.
  task automatic test_degenerate_curve();
    send_curve(same_point_curve($urandom, $urandom));
    send_curve(same_point_curve(32'sh0001_0000, 32'shffff_0000));
  endtask

  // A single non-zero anchor lands half-way between two codes at mid curve,
  // on both signs, so ties must round away from zero; a third curve then sets control points only.
  task automatic test_rounding_ties();
    curve_t c;
    c       = same_point_curve('0, '0);
    c.end_x = 32'sd4;
    c.end_y = -32'sd4;
    send_curve(c);
    c         = same_point_curve('0, '0);
    c.start_x = -32'sd4;
    c.start_y = 32'sd4;
    send_curve(c);
    c          = same_point_curve('0, '0);
    c.ctrl_a_x = 32'sd1;
    c.ctrl_b_y = -32'sd1;
    c.ctrl_a_y = 32'sd3;
    c.ctrl_b_x = -32'sd3;
    send_curve(c);
  endtask

  // The receiver holds off for a long stretch while curves keep coming, so the
  // block fills up and drops in_ready.
  task automatic test_output_hold();
    hold_request = 1'b1;
    repeat (6) begin
      send_curve(rand_curve());
    end
  endtask

  // Random curves: first back to back with no idling, then with idling on
  // both sides.
  task automatic test_random_curves();
    send_gaps_on = 1'b0;
    sink_idle_on = 1'b0;
    repeat (40) begin
      send_curve(rand_curve());
    end
    send_gaps_on = 1'b1;
    sink_idle_on = 1'b1;
    repeat (RANDOM_ITEMS - 40) begin
      send_curve(rand_curve());
    end
  endtask

  // Receiver: bursts of ready separated by stalls, plus the requested hold.
  initial begin : result_sink
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      // Keep the log bounded when the block is badly broken.
      if (fail_count <= REPORT_LIMIT) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  // Each accepted segment is compared with the oldest one predicted.
  always @(posedge clk) begin
    segment_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_segments.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $error("segment item with none expected: x0 %0d y0 %0d x1 %0d y1 %0d",
                 out_seg_x0, out_seg_y0, out_seg_x1, out_seg_y1);
        end
      end else begin
        want = expected_segments.pop_front();
        check_field("seg_x0", want.x0, out_seg_x0);
        check_field("seg_y0", want.y0, out_seg_y0);
        check_field("seg_x1", want.x1, out_seg_x1);
        check_field("seg_y1", want.y1, out_seg_y1);
        check_field("last_segment", want.last, out_last_segment);
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_range_extremes();
    test_degenerate_curve();
    test_rounding_ties();
    sink_idle_on = 1'b1;
    send_gaps_on = 1'b1;
    test_output_hold();
    test_random_curves();
    in_valid <= 1'b0;

    // Let the last segments drain, then allow for anything stray.
    wait (expected_segments.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_segments.size() != 0) begin
      fail_count++;
      $error("%0d segment items never arrived", expected_segments.size());
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/cbf_pkg.sv
hdl/cubic_bezier_flattener.sv
sim/cubic_bezier_flattener_test.sv
